// ----- rtl/image_meet_consensus_trim_core_assert.svh -----
// Assertion helpers for the meet consensus trim core.
// All properties sample on clk and are disabled while rst_n is low.
`ifndef IMAGE_MEET_CONSENSUS_TRIM_CORE_ASSERT_SVH
`define IMAGE_MEET_CONSENSUS_TRIM_CORE_ASSERT_SVH

// Implication in the same cycle.
`define IMCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imct: implication check failed");

// Condition that must never hold.
`define IMCT_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("imct: forbidden condition seen");

`endif

// ----- rtl/imct_pkg.sv -----
package imct_pkg;

    // Window geometry and pixel format
    localparam int MAX_WIDTH  = 8;
    localparam int MAX_HEIGHT = 8;
    localparam int PIXEL_BITS = 8;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 4;
    localparam int CFG_W   = 4;
    localparam int ENTRY_W = PIXEL_BITS + 1;

    // Two store banks: one loads while the other is emitted
    localparam int BANKS   = 2;
    localparam int BANK_W  = $clog2(BANKS);
    localparam int ADDR_W  = BANK_W + ROW_W + COL_W;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    // Window descriptor handed from front to back
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [ROW_W-1:0]  top;
        logic [COL_W-1:0]  left;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  width;
        logic              empty;
    } job_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_t;

    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] bank;
    } rel_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Zero reads as one, anything above the maximum saturates
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- rtl/imct_if.sv -----
interface imct_pair_if;
    logic                           valid;
    logic                           ready;
    logic [imct_pkg::PIXEL_BITS-1:0] image_pixel;
    logic [imct_pkg::PIXEL_BITS-1:0] bite_pixel;

    modport source (output valid, output image_pixel, output bite_pixel, input ready);
    modport sink   (input valid, input image_pixel, input bite_pixel, output ready);
endinterface

interface imct_meet_if;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     out_value;
    logic                           out_dont_care;
    logic [2:0]                     out_row;
    logic [2:0]                     out_col;
    logic [imct_pkg::DIM_W-1:0]     meet_height;
    logic [imct_pkg::DIM_W-1:0]     meet_width;
    logic                           meet_empty;
    logic                           last_of_run;

    modport source (output valid, output out_value, output out_dont_care, output out_row,
                    output out_col, output meet_height, output meet_width,
                    output meet_empty, output last_of_run, input ready);
    modport sink   (input valid, input out_value, input out_dont_care, input out_row,
                    input out_col, input meet_height, input meet_width,
                    input meet_empty, input last_of_run, output ready);
endinterface

// ----- rtl/imct_store.sv -----
module imct_store (
    input  logic                          clk,
    input  imct_pkg::wr_t                 wr,
    input  imct_pkg::rd_t                 rd,
    output logic [imct_pkg::ENTRY_W-1:0]  rd_data
);

    logic [imct_pkg::ENTRY_W-1:0] mem_reg [imct_pkg::BANKS*imct_pkg::MAX_HEIGHT*imct_pkg::MAX_WIDTH];
    logic [imct_pkg::ENTRY_W-1:0] rd_data_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem_reg[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/imct_queue.sv -----
module imct_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  imct_pkg::job_t      job_in,
    input  logic                pop,
    output imct_pkg::job_t      job_out,
    output imct_pkg::q_stat_t   stat
);

    imct_pkg::job_t                q_reg [imct_pkg::QDEPTH];
    logic [imct_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [imct_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [imct_pkg::QPTR_W:0]     count_reg,  count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign job_out    = q_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (imct_pkg::QPTR_W+1)'(imct_pkg::QDEPTH));

endmodule

// ----- rtl/imct_front.sv -----
module imct_front (
    input  logic                          clk,
    input  logic                          rst_n,
    imct_pair_if.sink                     pair_in,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [imct_pkg::CFG_W-1:0]    cfg_data,
    input  imct_pkg::rel_t                release_bank,
    output imct_pkg::wr_t                 wr,
    output logic                          push,
    output imct_pkg::job_t                job
);

    logic [imct_pkg::CFG_W-1:0]  width_reg;
    logic [imct_pkg::CFG_W-1:0]  height_reg;
    logic [imct_pkg::ROW_W-1:0]  load_row_reg;
    logic [imct_pkg::COL_W-1:0]  load_col_reg;
    logic [imct_pkg::ROW_W-1:0]  top_reg,    top_next;
    logic [imct_pkg::ROW_W-1:0]  bottom_reg, bottom_next;
    logic [imct_pkg::COL_W-1:0]  left_reg,   left_next;
    logic [imct_pkg::COL_W-1:0]  right_reg,  right_next;
    logic                        any_reg,    any_next;
    logic [imct_pkg::BANK_W-1:0] bank_reg;
    logic [imct_pkg::BANKS-1:0]  busy_reg,   busy_next;

    logic [imct_pkg::DIM_W-1:0]  w_eff;
    logic [imct_pkg::DIM_W-1:0]  h_eff;
    logic                        accept;
    logic                        match;
    logic                        col_last;
    logic                        row_last;
    logic                        win_done;

    assign w_eff = imct_pkg::clamp_dim(width_reg,  imct_pkg::DIM_W'(imct_pkg::MAX_WIDTH));
    assign h_eff = imct_pkg::clamp_dim(height_reg, imct_pkg::DIM_W'(imct_pkg::MAX_HEIGHT));

    // Stall while the bank being loaded is still being emitted
    assign pair_in.ready = !busy_reg[bank_reg];
    assign accept        = pair_in.valid && pair_in.ready;
    assign match         = (pair_in.image_pixel == pair_in.bite_pixel);

    assign col_last = (imct_pkg::DIM_W'(load_col_reg) + imct_pkg::DIM_W'(1)) >= w_eff;
    assign row_last = (imct_pkg::DIM_W'(load_row_reg) + imct_pkg::DIM_W'(1)) >= h_eff;
    assign win_done = accept && col_last && row_last;

    // Grow the bounding box on a match
    always_comb
    begin
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        any_next    = any_reg;
        if (match)
        begin
            if (load_row_reg < top_reg)    top_next    = load_row_reg;
            if (load_row_reg > bottom_reg) bottom_next = load_row_reg;
            if (load_col_reg < left_reg)   left_next   = load_col_reg;
            if (load_col_reg > right_reg)  right_next  = load_col_reg;
            any_next = 1'b1;
        end
    end

    // Store the value, or the don't-care mark
    assign wr.en   = accept;
    assign wr.addr = {bank_reg, load_row_reg, load_col_reg};
    assign wr.data = match ? {1'b0, pair_in.image_pixel}
                           : {1'b1, {imct_pkg::PIXEL_BITS{1'b0}}};

    // Describe the finished window
    assign push       = win_done;
    assign job.bank   = bank_reg;
    assign job.top    = top_next;
    assign job.left   = left_next;
    assign job.height = imct_pkg::DIM_W'(bottom_next) - imct_pkg::DIM_W'(top_next)
                        + imct_pkg::DIM_W'(1);
    assign job.width  = imct_pkg::DIM_W'(right_next) - imct_pkg::DIM_W'(left_next)
                        + imct_pkg::DIM_W'(1);
    assign job.empty  = !any_next;

    // Mark a bank busy on hand-off, free it when the back is done
    always_comb
    begin
        busy_next = busy_reg;
        if (release_bank.valid)
        begin
            busy_next[release_bank.bank] = 1'b0;
        end
        if (win_done)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= imct_pkg::CFG_W'(imct_pkg::MAX_WIDTH);
            height_reg   <= imct_pkg::CFG_W'(imct_pkg::MAX_HEIGHT);
            load_row_reg <= '0;
            load_col_reg <= '0;
            top_reg      <= imct_pkg::ROW_W'(imct_pkg::MAX_HEIGHT - 1);
            bottom_reg   <= '0;
            left_reg     <= imct_pkg::COL_W'(imct_pkg::MAX_WIDTH - 1);
            right_reg    <= '0;
            any_reg      <= 1'b0;
            bank_reg     <= '0;
            busy_reg     <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_we)
            begin
                // Any register write drops the window in progress
                case (imct_pkg::cfg_idx_t'(cfg_index))
                    imct_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    imct_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
                load_row_reg <= '0;
                load_col_reg <= '0;
                top_reg      <= imct_pkg::ROW_W'(imct_pkg::MAX_HEIGHT - 1);
                bottom_reg   <= '0;
                left_reg     <= imct_pkg::COL_W'(imct_pkg::MAX_WIDTH - 1);
                right_reg    <= '0;
                any_reg      <= 1'b0;
            end
            else if (accept)
            begin
                if (win_done)
                begin
                    // Restart in the other bank
                    load_row_reg <= '0;
                    load_col_reg <= '0;
                    top_reg      <= imct_pkg::ROW_W'(imct_pkg::MAX_HEIGHT - 1);
                    bottom_reg   <= '0;
                    left_reg     <= imct_pkg::COL_W'(imct_pkg::MAX_WIDTH - 1);
                    right_reg    <= '0;
                    any_reg      <= 1'b0;
                    bank_reg     <= bank_reg + 1'b1;
                end
                else
                begin
                    top_reg    <= top_next;
                    bottom_reg <= bottom_next;
                    left_reg   <= left_next;
                    right_reg  <= right_next;
                    any_reg    <= any_next;
                    if (col_last)
                    begin
                        load_col_reg <= '0;
                        load_row_reg <= load_row_reg + 1'b1;
                    end
                    else
                    begin
                        load_col_reg <= load_col_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/imct_back.sv -----
module imct_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imct_pkg::q_stat_t             q_stat,
    input  imct_pkg::job_t                job_in,
    output logic                          pop,
    output imct_pkg::rd_t                 rd,
    input  logic [imct_pkg::ENTRY_W-1:0]  rd_data,
    output imct_pkg::rel_t                release_bank,
    imct_meet_if.source                   meet_out
);

    logic                        active_reg;
    imct_pkg::job_t              job_reg;
    logic [imct_pkg::ROW_W-1:0]  i_reg;
    logic [imct_pkg::COL_W-1:0]  j_reg;

    logic                        pend_reg;
    logic [imct_pkg::ROW_W-1:0]  pend_row_reg;
    logic [imct_pkg::COL_W-1:0]  pend_col_reg;
    logic                        pend_last_reg;
    logic                        pend_empty_reg;

    logic                        out_valid_reg;
    logic [7:0]                  out_value_reg;
    logic                        out_dc_reg;
    logic [2:0]                  out_row_reg;
    logic [2:0]                  out_col_reg;
    logic [imct_pkg::DIM_W-1:0]  out_height_reg;
    logic [imct_pkg::DIM_W-1:0]  out_width_reg;
    logic                        out_empty_reg;
    logic                        out_last_reg;

    logic                        issue;
    logic                        row_end;
    logic                        col_end;
    logic                        elem_last;
    logic                        dc;

    // Take the next window when idle
    assign pop = !active_reg && !q_stat.empty;

    // Issue a read if none is pending and the output is free as it lands
    assign issue     = active_reg && !pend_reg && (!out_valid_reg || meet_out.ready);
    assign col_end   = (imct_pkg::DIM_W'(j_reg) + imct_pkg::DIM_W'(1)) == job_reg.width;
    assign row_end   = (imct_pkg::DIM_W'(i_reg) + imct_pkg::DIM_W'(1)) == job_reg.height;
    assign elem_last = job_reg.empty || (col_end && row_end);

    assign rd.en   = issue && !job_reg.empty;
    assign rd.addr = {job_reg.bank, job_reg.top + i_reg, job_reg.left + j_reg};

    // Bank is free once its last element has been captured
    assign release_bank.valid = pend_reg && pend_last_reg;
    assign release_bank.bank  = job_reg.bank;

    assign dc = rd_data[imct_pkg::PIXEL_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
            end
            else if (issue && elem_last)
            begin
                active_reg <= 1'b0;
            end
            pend_reg <= issue;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (meet_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk the cropped box in raster order
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job_in;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else if (issue)
        begin
            if (col_end)
            begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
        if (issue)
        begin
            pend_row_reg   <= i_reg;
            pend_col_reg   <= j_reg;
            pend_last_reg  <= elem_last;
            pend_empty_reg <= job_reg.empty;
        end
        if (pend_reg)
        begin
            out_value_reg  <= (pend_empty_reg || dc) ? 8'd0 : rd_data[7:0];
            out_dc_reg     <= !pend_empty_reg && dc;
            out_row_reg    <= pend_empty_reg ? 3'd0 : 3'(pend_row_reg);
            out_col_reg    <= pend_empty_reg ? 3'd0 : 3'(pend_col_reg);
            out_height_reg <= pend_empty_reg ? '0 : job_reg.height;
            out_width_reg  <= pend_empty_reg ? '0 : job_reg.width;
            out_empty_reg  <= pend_empty_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    assign meet_out.valid         = out_valid_reg;
    assign meet_out.out_value     = out_value_reg;
    assign meet_out.out_dont_care = out_dc_reg;
    assign meet_out.out_row       = out_row_reg;
    assign meet_out.out_col       = out_col_reg;
    assign meet_out.meet_height   = out_height_reg;
    assign meet_out.meet_width    = out_width_reg;
    assign meet_out.meet_empty    = out_empty_reg;
    assign meet_out.last_of_run   = out_last_reg;

endmodule

// ----- rtl/image_meet_consensus_trim_core.sv -----
// Loading: one pixel pair per cycle while the bank being filled is free.
// Emission: the store read is registered; a new read waits until the last one lands.
// A finished window's descriptor is queued until the back end is idle to read it out.
// Two store banks let the next window load while the previous one is emitted.
// Reset: rst_n is asynchronous, active low; window size returns to 8 by 8, no result pending.
`include "image_meet_consensus_trim_core_assert.svh"

module image_meet_consensus_trim_core (
    input  logic                          clk,
    input  logic                          rst_n,
    imct_pair_if.sink                     pair_in,
    imct_meet_if.source                   meet_out,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [imct_pkg::CFG_W-1:0]    cfg_data
);

    imct_pkg::wr_t                  wr;
    imct_pkg::rd_t                  rd;
    logic [imct_pkg::ENTRY_W-1:0]   rd_data;
    imct_pkg::rel_t                 release_bank;
    imct_pkg::job_t                 job_push;
    imct_pkg::job_t                 job_head;
    imct_pkg::q_stat_t              q_stat;
    logic                           q_push;
    logic                           q_pop;

    imct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_in      (pair_in),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .release_bank (release_bank),
        .wr           (wr),
        .push         (q_push),
        .job          (job_push)
    );

    imct_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (job_push),
        .pop     (q_pop),
        .job_out (job_head),
        .stat    (q_stat)
    );

    imct_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    imct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .job_in       (job_head),
        .pop          (q_pop),
        .rd           (rd),
        .rd_data      (rd_data),
        .release_bank (release_bank),
        .meet_out     (meet_out)
    );

    // Checks
    `IMCT_ASSERT_NEVER(a_queue_no_overflow, q_push && q_stat.full)
    `IMCT_ASSERT_NEVER(a_bank_no_collision,
        wr.en && rd.en && (wr.addr[imct_pkg::ADDR_W-1] == rd.addr[imct_pkg::ADDR_W-1]))
    `IMCT_ASSERT_IMP(a_empty_is_last, meet_out.valid && meet_out.meet_empty,
        meet_out.last_of_run)
    `IMCT_ASSERT_IMP(a_pos_in_box, meet_out.valid && !meet_out.meet_empty,
        ({1'b0, meet_out.out_row} < meet_out.meet_height) && ({1'b0, meet_out.out_col} < meet_out.meet_width))

endmodule

// ----- bench/image_meet_consensus_trim_core_tb.sv -----
`timescale 1ns / 1ps

module image_meet_consensus_trim_core_tb;

    localparam int CLK_HALF     = 4;
    localparam int DRAIN_SLACK  = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_PAIRS = 8;

    // One element of the emitted meet
    typedef struct packed {
        logic [7:0] value;
        logic       dont_care;
        logic [2:0] row;
        logic [2:0] col;
        logic [3:0] height;
        logic [3:0] width;
        logic       empty;
        logic       last;
    } meet_elem_t;

    // Consensus tracker: mirrors the store and the bounding box, queues the cropped meet
    class meet_scoreboard;
        logic [3:0]  width_reg;
        logic [3:0]  height_reg;
        logic [8:0]  consensus [64];
        int unsigned load_row, load_col;
        int unsigned box_top, box_bottom, box_left, box_right;
        bit          any_match;
        meet_elem_t  meet_q[$];
        int          errors;

        function new();
            width_reg  = 4'd8;
            height_reg = 4'd8;
            errors     = 0;
            foreach (consensus[k])
                consensus[k] = '0;
            restart();
        endfunction

        function void restart();
            load_row   = 0;
            load_col   = 0;
            box_top    = imct_pkg::MAX_HEIGHT - 1;
            box_bottom = 0;
            box_left   = imct_pkg::MAX_WIDTH - 1;
            box_right  = 0;
            any_match  = 0;
        endfunction

        function int unsigned eff_dim(logic [3:0] v, int unsigned maxv);
            if (v == 4'd0)
                return 1;
            if (v > maxv)
                return maxv;
            return 32'(v);
        endfunction

        function int unsigned window_pairs();
            return eff_dim(width_reg, imct_pkg::MAX_WIDTH)
                   * eff_dim(height_reg, imct_pkg::MAX_HEIGHT);
        endfunction

        function int pending();
            return meet_q.size();
        endfunction

        // Append one expected element
        function void add_expected(meet_elem_t e);
            meet_q = {meet_q, e};
        endfunction

        // Any write drops the window in progress
        function void write_reg(imct_pkg::cfg_idx_t idx, logic [3:0] val);
            if (idx == imct_pkg::CFG_WIDTH)
                width_reg = val;
            else
                height_reg = val;
            restart();
        endfunction

        function void emit_meet();
            meet_elem_t  e;
            int unsigned mh, mw, total, n;
            logic [8:0]  entry;
            n = 0;
            if (!any_match) begin
                e       = '0;
                e.empty = 1'b1;
                e.last  = 1'b1;
                add_expected(e);
                return;
            end
            mh    = box_bottom - box_top + 1;
            mw    = box_right - box_left + 1;
            total = mh * mw;
            for (int unsigned i = 0; i < mh; i++) begin
                for (int unsigned j = 0; j < mw; j++) begin
                    entry       = consensus[(box_top + i) * imct_pkg::MAX_WIDTH + box_left + j];
                    e.dont_care = entry[8];
                    e.value     = entry[8] ? 8'd0 : entry[7:0];
                    e.row       = 3'(i);
                    e.col       = 3'(j);
                    e.height    = 4'(mh);
                    e.width     = 4'(mw);
                    e.empty     = 1'b0;
                    e.last      = (n + 1 == total);
                    add_expected(e);
                    n++;
                end
            end
        endfunction

        // Store one accepted pair; close the window after its last position
        function void note_pair(logic [7:0] img, logic [7:0] bite);
            int unsigned w, h, r, c;
            w = eff_dim(width_reg, imct_pkg::MAX_WIDTH);
            h = eff_dim(height_reg, imct_pkg::MAX_HEIGHT);
            r = load_row;
            c = load_col;
            if (img == bite) begin
                consensus[r * imct_pkg::MAX_WIDTH + c] = {1'b0, img};
                if (r < box_top)    box_top    = r;
                if (r > box_bottom) box_bottom = r;
                if (c < box_left)   box_left   = c;
                if (c > box_right)  box_right  = c;
                any_match = 1;
            end else begin
                consensus[r * imct_pkg::MAX_WIDTH + c] = 9'h100;
            end
            if (c + 1 < w) begin
                load_col = c + 1;
            end else if (r + 1 < h) begin
                load_col = 0;
                load_row = r + 1;
            end else begin
                emit_meet();
                restart();
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(meet_elem_t got);
            meet_elem_t want;
            if (meet_q.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = meet_q.pop_front();
            check_field("out_value",     got.value,          want.value);
            check_field("out_dont_care", 8'(got.dont_care),  8'(want.dont_care));
            check_field("out_row",       8'(got.row),        8'(want.row));
            check_field("out_col",       8'(got.col),        8'(want.col));
            check_field("meet_height",   8'(got.height),     8'(want.height));
            check_field("meet_width",    8'(got.width),      8'(want.width));
            check_field("meet_empty",    8'(got.empty),      8'(want.empty));
            check_field("last_of_run",   8'(got.last),       8'(want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [imct_pkg::CFG_W-1:0] cfg_data;

    imct_pair_if pair_ch();
    imct_meet_if meet_ch();

    meet_scoreboard meet_model;
    int  stall_pct;
    int  gap_max;
    int  burst_left;
    int  pairs_sent;
    int  hold_requests;
    int  cycle_count = 0;

    image_meet_consensus_trim_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair_in  (pair_ch),
        .meet_out (meet_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("image_meet_consensus_trim_core test failed");
            $finish;
        end
    end

    // Observe both channels on the rising edge
    always @(posedge clk)
    begin
        meet_elem_t got;
        if (rst_n) begin
            if (pair_ch.valid && pair_ch.ready)
                meet_model.note_pair(pair_ch.image_pixel, pair_ch.bite_pixel);
            if (meet_ch.valid && meet_ch.ready) begin
                got.value     = meet_ch.out_value;
                got.dont_care = meet_ch.out_dont_care;
                got.row       = meet_ch.out_row;
                got.col       = meet_ch.out_col;
                got.height    = meet_ch.meet_height;
                got.width     = meet_ch.meet_width;
                got.empty     = meet_ch.meet_empty;
                got.last      = meet_ch.last_of_run;
                meet_model.check_result(got);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left      = 0;
        hold_served    = 0;
        meet_ch.ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                meet_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                meet_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offer one request; burst boundaries insert a random gap first
    task automatic send_pair(input logic [7:0] img, input logic [7:0] bite);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                pair_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        pair_ch.valid       <= 1'b1;
        pair_ch.image_pixel <= img;
        pair_ch.bite_pixel  <= bite;
        do
            @(posedge clk);
        while (!pair_ch.ready);
        pairs_sent++;
        @(negedge clk);
    endtask

    // Send one full window; match_pct sets how often the pixels agree
    task automatic send_window(input int match_pct);
        int         n;
        logic [7:0] img;
        logic [7:0] bite;
        n = meet_model.window_pairs();
        for (int k = 0; k < n; k++) begin
            img  = 8'($urandom_range(0, 255));
            bite = ($urandom_range(0, 99) < match_pct) ? img
                                                        : img ^ 8'($urandom_range(1, 255));
            send_pair(img, bite);
        end
    endtask

    task automatic write_cfg(input imct_pkg::cfg_idx_t idx, input logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        meet_model.write_reg(idx, val);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result is back, then let the pipe settle
    task automatic wait_idle();
        pair_ch.valid <= 1'b0;
        burst_left = 0;
        while (meet_model.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    function automatic logic [3:0] pick_dim();
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(1, 3));
    endfunction

    initial
    begin
        int pct_choices[5];
        int stall_choices[4];
        int gap_choices[3];
        int random_start;
        int nwin;

        pct_choices   = '{0, 10, 50, 90, 100};
        stall_choices = '{0, 25, 50, 80};
        gap_choices   = '{0, 2, 5};

        rst_n               = 1'b0;
        pair_ch.valid       = 1'b0;
        pair_ch.image_pixel = '0;
        pair_ch.bite_pixel  = '0;
        cfg_we              = 1'b0;
        cfg_index           = imct_pkg::CFG_WIDTH;
        cfg_data            = '0;
        stall_pct           = 30;
        gap_max             = 2;
        burst_left          = 0;
        pairs_sent          = 0;
        hold_requests       = 0;
        meet_model          = new();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-pixel window: match at both pixel extremes, then a mismatch
        write_cfg(imct_pkg::CFG_WIDTH, 4'd1);
        write_cfg(imct_pkg::CFG_HEIGHT, 4'd1);
        send_pair(8'h00, 8'h00);
        send_pair(8'hFF, 8'hFF);
        send_pair(8'h01, 8'h02);
        wait_idle();

        // Zero width reads as one column
        write_cfg(imct_pkg::CFG_WIDTH, 4'd0);
        send_pair(8'hAA, 8'h55);
        wait_idle();

        // Saturated width, zero height: one full row matched only at its ends
        write_cfg(imct_pkg::CFG_WIDTH, 4'd15);
        write_cfg(imct_pkg::CFG_HEIGHT, 4'd0);
        send_pair(8'hFF, 8'hFF);
        for (int k = 1; k < 7; k++)
            send_pair(8'(k), ~8'(k));
        send_pair(8'h00, 8'h00);
        wait_idle();

        // One column over all rows, matches only inside
        write_cfg(imct_pkg::CFG_WIDTH, 4'd1);
        write_cfg(imct_pkg::CFG_HEIGHT, 4'd9);
        for (int r = 0; r < 8; r++) begin
            if (r == 3)
                send_pair(8'h80, 8'h80);
            else if (r == 5)
                send_pair(8'h7F, 8'h7F);
            else
                send_pair(8'h10 + 8'(r), 8'h20 + 8'(r));
        end
        wait_idle();

        // Abandon a partial window with a register write
        write_cfg(imct_pkg::CFG_WIDTH, 4'd2);
        write_cfg(imct_pkg::CFG_HEIGHT, 4'd2);
        send_pair(8'h11, 8'h11);
        send_pair(8'h22, 8'h22);
        send_pair(8'h33, 8'h33);
        wait_idle();
        write_cfg(imct_pkg::CFG_HEIGHT, 4'd2);
        send_pair(8'h01, 8'h10);
        send_pair(8'h02, 8'h20);
        send_pair(8'h03, 8'h30);
        send_pair(8'hC4, 8'hC4);
        wait_idle();

        // Back-pressure: receiver holds off while small windows keep coming
        stall_pct = 0;
        gap_max   = 0;
        hold_requests++;
        repeat (3) send_window(60);
        wait_idle();

        // Full window, every pixel matching
        random_start = pairs_sent;
        stall_pct    = 20;
        gap_max      = 3;
        write_cfg(imct_pkg::CFG_WIDTH, 4'd8);
        write_cfg(imct_pkg::CFG_HEIGHT, 4'd8);
        send_window(100);
        wait_idle();

        // Random phases over varied window sizes, stall rates and gaps
        while (pairs_sent - random_start < RANDOM_PAIRS + 64) begin
            write_cfg(imct_pkg::CFG_WIDTH, pick_dim());
            write_cfg(imct_pkg::CFG_HEIGHT, pick_dim());
            stall_pct = stall_choices[$urandom_range(0, 3)];
            gap_max   = gap_choices[$urandom_range(0, 2)];
            nwin      = $urandom_range(1, 2);
            repeat (nwin) send_window(pct_choices[$urandom_range(0, 4)]);
            wait_idle();
        end

        wait_idle();
        repeat (2 * DRAIN_SLACK) @(negedge clk);
        if (meet_model.pending() != 0)
            meet_model.report("expected results never arrived");
        if (meet_model.errors == 0)
            $display("image_meet_consensus_trim_core test passed");
        else
            $display("image_meet_consensus_trim_core test failed");
        $finish;
    end

endmodule
